// ===== rtl/dnns_pkg.sv =====
// ----------------------------------------------------------------------------
// dnns_pkg
// Shared constants and codes for the directional nearest node search block.
// ----------------------------------------------------------------------------
package dnns_pkg;

  // Default geometry of the node grid.
  localparam int SHELLS_DEF     = 4;
  localparam int FACES_DEF      = 6;
  localparam int ROWS_DEF       = 8;
  localparam int COLS_DEF       = 8;
  localparam int COORD_BITS_DEF = 32;

  // Projection limit register, Q15.16, resets to 1000.0.
  localparam int              MAXP_W   = 31;
  localparam logic [MAXP_W-1:0] MAXP_RST = 31'd65536000;

  // Tangent vectors are Q2.30 held in 32 signed bits.
  localparam int DIR_W = 32;
  localparam int FRAC  = 30;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_QUERY    = 2'd1,
    REQ_QUERY_EX = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_WEST  = 2'd2,
    DIR_SOUTH = 2'd3
  } dir_t;

endpackage

// ===== rtl/dnns_ram.sv =====
// ----------------------------------------------------------------------------
// dnns_ram
// Generic single port RAM with one write or read per cycle and registered
// read data.
// ----------------------------------------------------------------------------
module dnns_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/directional_nearest_node_search_top.sv =====
// ----------------------------------------------------------------------------
// directional_nearest_node_search_top
// Node position store with a four way directional nearest node search.
// ----------------------------------------------------------------------------
// Sequence: a node write is stored while idle. A query runs squaring, square
// roots, divisions and products, then four scans over the FACES*ROWS*COLS
// nodes of its shell, then four result words. The scans are bound by the node
// memory's one read port.
// Throughput: one item at a time; after a query the next word is taken after its last result.
// Reset: synchronous, active low; clears control and sets the limit to 1000.0.
// The node memory is not cleared, and an unwritten node reads as garbage.
module directional_nearest_node_search_top
  import dnns_pkg::*;
#(
  parameter int SHELLS     = SHELLS_DEF,
  parameter int FACES      = FACES_DEF,
  parameter int ROWS       = ROWS_DEF,
  parameter int COLS       = COLS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration port.
  input  logic              cfg_we,
  input  logic [MAXP_W-1:0] cfg_wdata,
  // Input channel.
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [1:0]        in_shell,
  input  logic [2:0]        in_face,
  input  logic [2:0]        in_row,
  input  logic [2:0]        in_col,
  input  logic [31:0]       in_pos_x,
  input  logic [31:0]       in_pos_y,
  input  logic [31:0]       in_pos_z,
  // Result channel.
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_direction,
  output logic [2:0]        out_found_face,
  output logic [3:0]        out_found_row,
  output logic [3:0]        out_found_col,
  output logic              out_found,
  output logic              out_last
);

  localparam int NPS   = FACES * ROWS * COLS;
  localparam int DEPTH = SHELLS * NPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = (FACES > 1) ? $clog2(FACES) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CB    = COORD_BITS;
  localparam int MW    = 3 * CB;
  // Offset, product, truncated term and projection sum widths.
  localparam int DW    = CB + 1;
  localparam int PRW   = DW + DIR_W;
  localparam int TW    = PRW - FRAC;
  localparam int SW    = TW + 2;
  localparam int BW    = (SW > 32) ? SW : 32;

  localparam logic signed [PRW-1:0] BIAS_P = PRW'((2 ** FRAC) - 1);
  localparam logic signed [63:0]    BIAS_S = 64'((2 ** FRAC) - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQ   = 7'b0000010,
    ST_SQRT = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_SMUL = 7'b0010000,
    ST_SCAN = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [FW-1:0] f;
    logic [RW-1:0] r;
    logic [CW-1:0] c;
  } node_t;

  // Magnitude of a coordinate, zero extended to 32 bits.
  function automatic logic [31:0] mag_of(input logic signed [CB-1:0] v);
    logic signed [CB:0] e;
    e = v;
    if (e < 0) begin
      e = -e;
    end
    return 32'(e[CB-1:0]);
  endfunction

  // Drop 30 fraction bits, rounding toward zero.
  function automatic logic signed [TW-1:0] trunc_p(input logic signed [PRW-1:0] v);
    logic signed [PRW-1:0] b;
    b = v[PRW-1] ? (v + BIAS_P) : v;
    return b[PRW-1:FRAC];
  endfunction

  function automatic logic signed [31:0] trunc_s(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v[63] ? (v + BIAS_S) : v;
    return b[FRAC+31:FRAC];
  endfunction

  // ---------------------------------------------------------------- registers
  state_t              state_r;
  logic [5:0]          step_r;
  logic [1:0]          sub_r;
  logic [1:0]          dk_r;
  logic [MAXP_W-1:0]   max_proj_r;

  logic signed [CB-1:0] pt_r [3];
  logic [31:0]          mag_r [3];
  logic [2:0]           sgn_r;
  logic [1:0]           shell_r;
  logic                 ex_v_r;
  node_t                ex_r;

  logic [63:0]          prod_r;
  logic [63:0]          sxy_r;
  logic [63:0]          smag_r;
  logic [63:0]          sqv_r;
  logic [63:0]          sqres_r;
  logic [63:0]          sqbit_r;
  logic [31:0]          rper_r;
  logic [31:0]          rmag_r;
  logic [61:0]          qn_r;
  logic [31:0]          rem_r;
  logic                 dsign_r;
  logic signed [31:0]   cz_r, ux_r, uy_r, s2_r, s0_r, s1_r;

  logic [AW-1:0]        addr_r;
  node_t                cnt_r;
  logic                 issuing_r;
  logic [3:0]           pend_r;
  logic [3:0]           vld_r;
  node_t                tag_r [4];
  logic signed [DW-1:0] d_r [3];
  logic signed [PRW-1:0] pr_r [3];
  logic signed [SW-1:0] p_r;
  logic signed [BW-1:0] best_r;
  logic                 cur_v_r;
  node_t                cur_r;
  logic [3:0]           win_v_r;
  node_t                win_r [4];

  // ------------------------------------------------------------- memory port
  logic              acc_in;
  logic              w_inrange;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [MW-1:0]     ram_wdata;
  logic [MW-1:0]     ram_rdata;
  logic [31:0]       waddr_full;
  logic [31:0]       base_full;

  assign acc_in   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  assign w_inrange = (32'(in_shell) < SHELLS) && (32'(in_face) < FACES) &&
                     (32'(in_row) < ROWS) && (32'(in_col) < COLS);
  assign waddr_full = ((32'(in_shell) * FACES + 32'(in_face)) * ROWS + 32'(in_row)) * COLS
                      + 32'(in_col);
  assign base_full  = 32'(shell_r) * NPS;

  assign ram_we    = acc_in && (in_req_type == REQ_WRITE) && w_inrange;
  assign ram_addr  = (state_r == ST_IDLE) ? waddr_full[AW-1:0] : addr_r;
  assign ram_wdata = {in_pos_z[CB-1:0], in_pos_y[CB-1:0], in_pos_x[CB-1:0]};

  dnns_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ----------------------------------------------------- setup arithmetic
  // Squares go through one 32x32 multiplier, one axis per cycle.
  logic [31:0] msel_c;
  logic [63:0] sq_c;

  always_comb begin
    unique case (step_r[1:0])
      2'd0:    msel_c = mag_r[0];
      2'd1:    msel_c = mag_r[1];
      default: msel_c = mag_r[2];
    endcase
  end
  assign sq_c = msel_c * msel_c;

  // Square root by the bitwise shift-and-subtract method.
  logic [63:0] sq_t;
  logic        sq_ge;
  logic [63:0] sqres_nxt;

  assign sq_t      = sqres_r + sqbit_r;
  assign sq_ge     = (sqv_r >= sq_t);
  assign sqres_nxt = sq_ge ? ((sqres_r >> 1) + sqbit_r) : (sqres_r >> 1);

  // Restoring divider, one quotient bit per cycle. The quotients are known
  // to stay within 2^30, so only the low 31 bits are kept.
  logic [31:0]        den_c;
  logic [32:0]        dv_sh;
  logic               dv_ge;
  logic [32:0]        rem_nxt;
  logic [61:0]        q_c;
  logic signed [31:0] qv_c;
  logic [1:0]         nidx_c;
  logic [61:0]        num_c;
  logic               nsgn_c;

  assign den_c   = ((sub_r == 2'd1) || (sub_r == 2'd2)) ? rper_r : rmag_r;
  assign dv_sh   = {rem_r, qn_r[61]};
  assign dv_ge   = (dv_sh >= {1'b0, den_c});
  assign rem_nxt = dv_ge ? (dv_sh - {1'b0, den_c}) : dv_sh;
  assign q_c     = {qn_r[60:0], dv_ge};
  assign qv_c    = dsign_r ? -$signed({1'b0, q_c[30:0]}) : $signed({1'b0, q_c[30:0]});

  // Dividend order: z over rmag, x over rper, y over rper, rper over rmag.
  assign nidx_c = (state_r == ST_SQRT) ? 2'd0 : (sub_r + 2'd1);
  always_comb begin
    unique case (nidx_c)
      2'd0: begin
        num_c  = {mag_r[2], 30'b0};
        nsgn_c = sgn_r[2];
      end
      2'd1: begin
        num_c  = {mag_r[0], 30'b0};
        nsgn_c = sgn_r[0];
      end
      2'd2: begin
        num_c  = {mag_r[1], 30'b0};
        nsgn_c = sgn_r[1];
      end
      default: begin
        num_c  = {rper_r, 30'b0};
        nsgn_c = 1'b0;
      end
    endcase
  end

  // Horizontal parts of the south vector.
  logic signed [63:0] sp_c;
  assign sp_c = cz_r * ((step_r == 6'd0) ? ux_r : uy_r);

  // ------------------------------------------------------------ scan logic
  logic signed [31:0]    dir_c [3];
  logic                  skip_c;
  logic                  last_c;
  logic signed [CB-1:0]  nd_c [3];
  logic signed [DW-1:0]  d_c [3];
  logic signed [SW-1:0]  psum_c;
  logic signed [BW-1:0]  pext_c;

  // North is the negated south vector, west the negated east vector.
  always_comb begin
    unique case (dk_r)
      DIR_NORTH: begin
        dir_c[0] = -s0_r;
        dir_c[1] = -s1_r;
        dir_c[2] = s2_r;
      end
      DIR_EAST: begin
        dir_c[0] = -uy_r;
        dir_c[1] = ux_r;
        dir_c[2] = '0;
      end
      DIR_WEST: begin
        dir_c[0] = uy_r;
        dir_c[1] = -ux_r;
        dir_c[2] = '0;
      end
      default: begin
        dir_c[0] = s0_r;
        dir_c[1] = s1_r;
        dir_c[2] = -s2_r;
      end
    endcase
  end

  // East and west skip the north winner; south skips the east and west ones.
  always_comb begin
    skip_c = ex_v_r && (cnt_r == ex_r);
    if ((dk_r == DIR_EAST) || (dk_r == DIR_WEST)) begin
      skip_c = skip_c || (win_v_r[DIR_NORTH] && (cnt_r == win_r[DIR_NORTH]));
    end
    if (dk_r == DIR_SOUTH) begin
      skip_c = skip_c || (win_v_r[DIR_EAST] && (cnt_r == win_r[DIR_EAST])) ||
               (win_v_r[DIR_WEST] && (cnt_r == win_r[DIR_WEST]));
    end
  end

  assign last_c = (cnt_r.f == FW'(FACES - 1)) && (cnt_r.r == RW'(ROWS - 1)) &&
                  (cnt_r.c == CW'(COLS - 1));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nd_c[i] = ram_rdata[i*CB +: CB];
      d_c[i]  = DW'(nd_c[i]) - DW'(pt_r[i]);
    end
  end

  assign psum_c = SW'(trunc_p(pr_r[0])) + SW'(trunc_p(pr_r[1])) + SW'(trunc_p(pr_r[2]));
  assign pext_c = BW'(p_r);

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= '0;
      sub_r      <= '0;
      dk_r       <= '0;
      max_proj_r <= MAXP_RST;
      issuing_r  <= 1'b0;
      pend_r     <= '0;
      vld_r      <= '0;
      win_v_r    <= '0;
      cur_v_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_proj_r <= cfg_wdata;
      end

      // Projection pipeline: read, offset, product, sum, compare.
      pend_r   <= {pend_r[2:0], issuing_r};
      vld_r    <= {vld_r[2:0], !skip_c};
      tag_r[0] <= cnt_r;
      tag_r[1] <= tag_r[0];
      tag_r[2] <= tag_r[1];
      tag_r[3] <= tag_r[2];
      for (int i = 0; i < 3; i++) begin
        d_r[i]  <= d_c[i];
        pr_r[i] <= d_r[i] * dir_c[i];
      end
      p_r <= psum_c;

      unique case (state_r)
        ST_IDLE: begin
          if (acc_in) begin
            pt_r[0]  <= in_pos_x[CB-1:0];
            pt_r[1]  <= in_pos_y[CB-1:0];
            pt_r[2]  <= in_pos_z[CB-1:0];
            mag_r[0] <= mag_of(in_pos_x[CB-1:0]);
            mag_r[1] <= mag_of(in_pos_y[CB-1:0]);
            mag_r[2] <= mag_of(in_pos_z[CB-1:0]);
            sgn_r    <= {in_pos_z[CB-1], in_pos_y[CB-1], in_pos_x[CB-1]};
            shell_r  <= in_shell;
            ex_v_r   <= (in_req_type == REQ_QUERY_EX) && (32'(in_face) < FACES) &&
                        (32'(in_row) < ROWS) && (32'(in_col) < COLS);
            ex_r.f   <= FW'(in_face);
            ex_r.r   <= RW'(in_row);
            ex_r.c   <= CW'(in_col);
            win_v_r  <= '0;
            dk_r     <= '0;
            step_r   <= '0;
            if ((in_req_type == REQ_QUERY) || (in_req_type == REQ_QUERY_EX)) begin
              // A shell beyond the grid finds nothing in any direction.
              state_r <= (32'(in_shell) < SHELLS) ? ST_SQ : ST_OUT;
            end
          end
        end

        ST_SQ: begin
          step_r <= step_r + 6'd1;
          prod_r <= sq_c;
          if (step_r == 6'd1) begin
            sxy_r <= prod_r;
          end else if (step_r == 6'd2) begin
            sxy_r <= sxy_r + prod_r;
          end else if (step_r == 6'd3) begin
            smag_r  <= sxy_r + prod_r;
            sqv_r   <= sxy_r;
            sqres_r <= '0;
            sqbit_r <= 64'h4000_0000_0000_0000;
            step_r  <= '0;
            sub_r   <= '0;
            state_r <= ST_SQRT;
          end
        end

        ST_SQRT: begin
          step_r  <= step_r + 6'd1;
          sqres_r <= sqres_nxt;
          sqbit_r <= sqbit_r >> 2;
          if (sq_ge) begin
            sqv_r <= sqv_r - sq_t;
          end
          if (step_r == 6'd31) begin
            step_r <= '0;
            if (sub_r == 2'd0) begin
              rper_r <= sqres_nxt[31:0];
              if (sqres_nxt == '0) begin
                // On the polar axis there is no tangent frame, so nothing is found.
                state_r <= ST_OUT;
              end else begin
                sqv_r   <= smag_r;
                sqres_r <= '0;
                sqbit_r <= 64'h4000_0000_0000_0000;
                sub_r   <= 2'd1;
              end
            end else begin
              rmag_r  <= sqres_nxt[31:0];
              qn_r    <= num_c;
              dsign_r <= nsgn_c;
              rem_r   <= '0;
              sub_r   <= '0;
              state_r <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          step_r <= step_r + 6'd1;
          rem_r  <= rem_nxt[31:0];
          qn_r   <= q_c;
          if (step_r == 6'd61) begin
            step_r <= '0;
            unique case (sub_r)
              2'd0:    cz_r <= qv_c;
              2'd1:    ux_r <= qv_c;
              2'd2:    uy_r <= qv_c;
              default: s2_r <= qv_c;
            endcase
            if (sub_r == 2'd3) begin
              state_r <= ST_SMUL;
            end else begin
              sub_r   <= sub_r + 2'd1;
              qn_r    <= num_c;
              dsign_r <= nsgn_c;
              rem_r   <= '0;
            end
          end
        end

        ST_SMUL: begin
          step_r <= step_r + 6'd1;
          prod_r <= sp_c;
          if (step_r == 6'd1) begin
            s0_r <= trunc_s(prod_r);
          end else if (step_r == 6'd2) begin
            s1_r      <= trunc_s(prod_r);
            step_r    <= '0;
            addr_r    <= base_full[AW-1:0];
            cnt_r     <= '0;
            issuing_r <= 1'b1;
            best_r    <= BW'(max_proj_r);
            cur_v_r   <= 1'b0;
            state_r   <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (issuing_r) begin
            addr_r <= addr_r + AW'(1);
            if (cnt_r.c == CW'(COLS - 1)) begin
              cnt_r.c <= '0;
              if (cnt_r.r == RW'(ROWS - 1)) begin
                cnt_r.r <= '0;
                cnt_r.f <= cnt_r.f + FW'(1);
              end else begin
                cnt_r.r <= cnt_r.r + RW'(1);
              end
            end else begin
              cnt_r.c <= cnt_r.c + CW'(1);
            end
            if (last_c) begin
              issuing_r <= 1'b0;
            end
          end
          // Strict compare keeps the earliest node on a tie.
          if (pend_r[3] && vld_r[3] && (p_r > 0) && (pext_c < best_r)) begin
            best_r  <= pext_c;
            cur_v_r <= 1'b1;
            cur_r   <= tag_r[3];
          end
          if (!issuing_r && (pend_r == '0)) begin
            win_v_r[dk_r] <= cur_v_r;
            win_r[dk_r]   <= cur_r;
            if (dk_r == DIR_SOUTH) begin
              dk_r    <= '0;
              state_r <= ST_OUT;
            end else begin
              dk_r      <= dk_r + 2'd1;
              addr_r    <= base_full[AW-1:0];
              cnt_r     <= '0;
              issuing_r <= 1'b1;
              best_r    <= BW'(max_proj_r);
              cur_v_r   <= 1'b0;
            end
          end
        end

        ST_OUT: begin
          if (!out_stall) begin
            if (dk_r == DIR_SOUTH) begin
              dk_r    <= '0;
              state_r <= ST_IDLE;
            end else begin
              dk_r <= dk_r + 2'd1;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------- result words
  // A missing winner reports the grid sizes as its indices.
  assign out_valid      = (state_r == ST_OUT);
  assign out_direction  = dk_r;
  assign out_found      = win_v_r[dk_r];
  assign out_found_face = win_v_r[dk_r] ? 3'(win_r[dk_r].f) : 3'(FACES);
  assign out_found_row  = win_v_r[dk_r] ? 4'(win_r[dk_r].r) : 4'(ROWS);
  assign out_found_col  = win_v_r[dk_r] ? 4'(win_r[dk_r].c) : 4'(COLS);
  assign out_last       = (dk_r == DIR_SOUTH);

endmodule

// ===== test/tb_directional_nearest_node_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_directional_nearest_node_search_top
// Self-checking bench for the directional nearest node search block. It fills
// one shell with node positions, runs directed and random node writes and
// queries under several projection limits, predicts the four direction words
// of every query and checks them in order against the result channel.
// ----------------------------------------------------------------------------
module tb_directional_nearest_node_search_top;
  import dnns_pkg::*;

  localparam int NODES_PER_SHELL = FACES_DEF * ROWS_DEF * COLS_DEF;
  localparam int NODE_COUNT      = SHELLS_DEF * NODES_PER_SHELL;
  localparam int IDLE_LIMIT      = 20000;
  localparam logic [30:0] LIMIT_TOP = 31'h7FFFFFFF;
  localparam longint ONE_Q30     = 64'sd1073741824;

  // One word of the result channel.
  typedef struct {
    dir_t     direction;
    bit [2:0] face;
    bit [3:0] row;
    bit [3:0] col;
    bit       found;
    bit       last;
  } hit_t;

  // One word of the input channel.
  typedef struct {
    req_t      kind;
    bit [1:0]  shell;
    bit [2:0]  face;
    bit [2:0]  row;
    bit [2:0]  col;
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] z;
  } req_word_t;

  // Scan winner: whether there is one and its index within the shell.
  typedef struct {
    bit valid;
    int idx;
  } pick_t;

  // Keeps a copy of the node store and the limit, and queues the four
  // direction words that each accepted query must produce.
  class node_search_board;
    int          node_pos[NODE_COUNT][3];
    bit [30:0]   proj_limit;
    hit_t        pending_hits[$];
    int          errors;

    function new();
      proj_limit = MAXP_RST;
      errors     = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    static function longint unsigned root64(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned b   = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Drop 30 fraction bits, rounding toward zero.
    static function longint drop_q30(longint v);
      if (v < 0) return -((-v) >> 30);
      return v >> 30;
    endfunction

    function pick_t nearest(int base, longint pt[3], longint dir[3], pick_t ex[3], int nex);
      pick_t  win;
      longint best;
      longint p;
      bit     skip;
      win.valid = 0;
      win.idx   = 0;
      best      = longint'(proj_limit);
      for (int i = 0; i < NODES_PER_SHELL; i++) begin
        skip = 0;
        for (int k = 0; k < nex; k++)
          if (ex[k].valid && ex[k].idx == i) skip = 1;
        if (!skip) begin
          p = 0;
          for (int a = 0; a < 3; a++)
            p += drop_q30((longint'(node_pos[base + i][a]) - pt[a]) * dir[a]);
          if (p > 0 && p < best) begin
            best      = p;
            win.valid = 1;
            win.idx   = i;
          end
        end
      end
      return win;
    endfunction

    function void push_hit(dir_t d, pick_t w);
      hit_t h;
      h.direction = d;
      h.face      = w.valid ? 3'(w.idx / (COLS_DEF * ROWS_DEF)) : 3'(FACES_DEF);
      h.row       = w.valid ? 4'((w.idx / COLS_DEF) % ROWS_DEF) : 4'(ROWS_DEF);
      h.col       = w.valid ? 4'(w.idx % COLS_DEF) : 4'(COLS_DEF);
      h.found     = w.valid;
      h.last      = (d == DIR_SOUTH);
      pending_hits.push_back(h);
    endfunction

    // Notes an accepted input word: updates the store or predicts a query.
    function void note_word(req_word_t w);
      longint          pt[3], north[3], east[3], west[3], south[3];
      longint unsigned ax, ay, az, sxy;
      longint          rper, rmag, cz, ux, uy;
      pick_t           ex[3], nw, ew, ww, sw, none;
      int              base;
      pt[0] = longint'($signed(w.x));
      pt[1] = longint'($signed(w.y));
      pt[2] = longint'($signed(w.z));
      if (w.kind == REQ_WRITE) begin
        if (w.face < FACES_DEF)
          for (int a = 0; a < 3; a++)
            node_pos[((w.shell * FACES_DEF + w.face) * ROWS_DEF + w.row) * COLS_DEF + w.col][a]
              = int'(pt[a]);
        return;
      end
      if (w.kind == REQ_NONE) return;

      ax   = pt[0] < 0 ? -pt[0] : pt[0];
      ay   = pt[1] < 0 ? -pt[1] : pt[1];
      az   = pt[2] < 0 ? -pt[2] : pt[2];
      sxy  = ax * ax + ay * ay;
      rper = root64(sxy);
      rmag = root64(sxy + az * az);
      for (int a = 0; a < 3; a++) begin
        east[a]  = 0;
        south[a] = 0;
      end
      // On the polar axis every tangent stays zero and nothing is found.
      if (rper > 0 && rmag > 0) begin
        cz       = pt[2] * ONE_Q30 / rmag;
        ux       = pt[0] * ONE_Q30 / rper;
        uy       = pt[1] * ONE_Q30 / rper;
        east[0]  = -uy;
        east[1]  = ux;
        south[0] = drop_q30(cz * ux);
        south[1] = drop_q30(cz * uy);
        south[2] = -(rper * ONE_Q30 / rmag);
      end
      for (int a = 0; a < 3; a++) begin
        west[a]  = -east[a];
        north[a] = -south[a];
      end

      base        = w.shell * NODES_PER_SHELL;
      none.valid  = 0;
      none.idx    = 0;
      ex[0].valid = (w.kind == REQ_QUERY_EX) && (w.face < FACES_DEF);
      ex[0].idx   = (w.face * ROWS_DEF + w.row) * COLS_DEF + w.col;
      ex[1]       = none;
      ex[2]       = none;
      nw          = nearest(base, pt, north, ex, 1);
      ex[1]       = nw;
      ew          = nearest(base, pt, east, ex, 2);
      ww          = nearest(base, pt, west, ex, 2);
      ex[1]       = ew;
      ex[2]       = ww;
      sw          = nearest(base, pt, south, ex, 3);
      push_hit(DIR_NORTH, nw);
      push_hit(DIR_EAST, ew);
      push_hit(DIR_WEST, ww);
      push_hit(DIR_SOUTH, sw);
    endfunction

    task check_word(logic [1:0] d, logic [2:0] f, logic [3:0] r, logic [3:0] c,
                    logic fnd, logic lst);
      hit_t h;
      if (pending_hits.size() == 0) begin
        report($sformatf("unexpected result word dir=%0d", d));
        return;
      end
      h = pending_hits.pop_front();
      if (d !== h.direction || f !== h.face || r !== h.row || c !== h.col ||
          fnd !== h.found || lst !== h.last)
        report($sformatf("got dir=%0d node=%0d/%0d/%0d found=%0d last=%0d, want dir=%0d node=%0d/%0d/%0d found=%0d last=%0d",
                         d, f, r, c, fnd, lst, h.direction, h.face, h.row, h.col, h.found, h.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [30:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [1:0]  in_shell;
  logic [2:0]  in_face;
  logic [2:0]  in_row;
  logic [2:0]  in_col;
  logic [31:0] in_pos_x;
  logic [31:0] in_pos_y;
  logic [31:0] in_pos_z;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_direction;
  logic [2:0]  out_found_face;
  logic [3:0]  out_found_row;
  logic [3:0]  out_found_col;
  logic        out_found;
  logic        out_last;

  node_search_board board;
  int burst_left;
  int idle_cycles;
  int stall_cycle;

  directional_nearest_node_search_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_shell       (in_shell),
    .in_face        (in_face),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_direction  (out_direction),
    .out_found_face (out_found_face),
    .out_found_row  (out_found_row),
    .out_found_col  (out_found_col),
    .out_found      (out_found),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Coordinates within about 60.0 of the origin keep most projections under
  // the default limit, so the scans actually pick winners.
  function automatic bit [31:0] near_coord();
    return 32'($urandom_range(0, 120 * 65536) - 60 * 65536);
  endfunction

  function automatic req_word_t make_word(req_t kind, int shell, int face, int row, int col,
                                          bit [31:0] x, bit [31:0] y, bit [31:0] z);
    req_word_t w;
    w.kind  = kind;
    w.shell = 2'(shell);
    w.face  = 3'(face);
    w.row   = 3'(row);
    w.col   = 3'(col);
    w.x     = x;
    w.y     = y;
    w.z     = z;
    return w;
  endfunction

  // Presents one word and holds it until the block takes it. The valid is
  // only lowered when a gap follows, so back-to-back words never glitch it.
  task automatic send_word(req_word_t w, bit bursty);
    in_valid    <= 1'b1;
    in_req_type <= w.kind;
    in_shell    <= w.shell;
    in_face     <= w.face;
    in_row      <= w.row;
    in_col      <= w.col;
    in_pos_x    <= w.x;
    in_pos_y    <= w.y;
    in_pos_z    <= w.z;
    do @(posedge clk); while (in_stall);
    board.note_word(w);
    if (bursty) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Holds the sender back until every predicted word has come out, then a
  // few more cycles so the block is surely back in its idle state.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending_hits.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(bit [30:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    board.proj_limit = value;
    cfg_we <= 1'b0;
  endtask

  task automatic send_query(req_t kind, int shell, int face, int row, int col,
                            bit [31:0] x, bit [31:0] y, bit [31:0] z);
    send_word(make_word(kind, shell, face, row, col, x, y, z), 1'b0);
  endtask

  // The receiver cycles through three moods: never stalling, stalling at
  // random about a quarter of the time, and stalling five sevenths of the time.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 700) % 3)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= (stall_cycle % 7) < 5;
      end
    endcase
  end

  // Result monitor: every word taken from the block is checked in order.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word(out_direction, out_found_face, out_found_row, out_found_col,
                       out_found, out_last);
  end

  // Watchdog: too many cycles without any handshake means the block hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    req_word_t w;
    int        pick;
    bit [30:0] phase_limit[4];

    board        = new();
    burst_left   = 0;
    idle_cycles  = 0;
    stall_cycle  = 0;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_WRITE;
    in_shell    <= '0;
    in_face     <= '0;
    in_row      <= '0;
    in_col      <= '0;
    in_pos_x    <= '0;
    in_pos_y    <= '0;
    in_pos_z    <= '0;
    out_stall   <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unwritten nodes read back as garbage, so shell 0 is filled completely
    // before any query; only that shell is ever searched.
    for (int i = 0; i < NODES_PER_SHELL; i++)
      send_word(make_word(REQ_WRITE, 0, i / 64, (i / 8) % 8, i % 8,
                          near_coord(), near_coord(), near_coord()), 1'b1);

    // Directed words: plain and excluding queries, the polar axis, extreme
    // coordinates, an ignored request type, node writes and out of range writes.
    send_query(REQ_QUERY, 0, 7, 7, 7, near_coord(), near_coord(), near_coord());
    send_query(REQ_QUERY, 0, 0, 0, 0, 32'd0, 32'd0, 32'sd3276800);
    send_query(REQ_QUERY, 0, 0, 0, 0, 32'd0, 32'd0, 32'd0);
    send_query(REQ_QUERY, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_query(REQ_QUERY, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_query(REQ_QUERY, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h0);
    send_query(REQ_QUERY_EX, 0, 0, 0, 0, near_coord(), near_coord(), near_coord());
    send_query(REQ_QUERY_EX, 0, 5, 7, 7, near_coord(), near_coord(), near_coord());
    send_query(REQ_QUERY_EX, 0, 7, 3, 5, near_coord(), near_coord(), near_coord());
    send_query(REQ_NONE, 3, 7, 7, 7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_query(REQ_WRITE, 0, 6, 7, 7, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_query(REQ_WRITE, 0, 5, 7, 7, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_query(REQ_WRITE, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_query(REQ_QUERY, 0, 0, 0, 0, near_coord(), near_coord(), near_coord());
    send_query(REQ_WRITE, 3, 7, 7, 7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);

    // The limit at its extremes: nothing can count at zero, and at the top
    // value only projections beyond the register's range are kept out.
    write_limit(31'd0);
    send_query(REQ_QUERY, 0, 0, 0, 0, near_coord(), near_coord(), near_coord());
    write_limit(LIMIT_TOP);
    send_query(REQ_QUERY, 0, 0, 0, 0, near_coord(), near_coord(), near_coord());
    send_query(REQ_QUERY_EX, 0, 2, 4, 6, 32'h80000000, 32'h00000001, 32'h7FFFFFFF);

    // Random phases, each under its own limit. Most words are node writes to
    // shells 0 and 1 and queries on the filled shell; the rest are writes to the
    // other shells, out of range writes and ignored request types.
    phase_limit[0] = MAXP_RST;
    phase_limit[1] = LIMIT_TOP;
    phase_limit[2] = 31'd655360;
    phase_limit[3] = 31'($urandom_range(0, 200 * 65536));
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(phase_limit[ph]);
      for (int n = 0; n < 8; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          w = make_word(REQ_WRITE, $urandom_range(0, 1), $urandom_range(0, 5),
                        $urandom_range(0, 7), $urandom_range(0, 7),
                        near_coord(), near_coord(), near_coord());
        else if (pick < 55)
          w = make_word(REQ_WRITE, $urandom_range(2, 3), $urandom_range(0, 5),
                        $urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom(), $urandom(), $urandom());
        else if (pick < 60)
          w = make_word(REQ_WRITE, $urandom_range(0, 3), $urandom_range(6, 7),
                        $urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom(), $urandom(), $urandom());
        else if (pick < 64)
          w = make_word(REQ_NONE, $urandom_range(0, 3), $urandom_range(0, 7),
                        $urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom(), $urandom(), $urandom());
        else
          w = make_word(pick < 84 ? REQ_QUERY : REQ_QUERY_EX, 0,
                        $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                        near_coord(), near_coord(), near_coord());
        // Now and then a query point anywhere in the coordinate range.
        if (w.kind inside {REQ_QUERY, REQ_QUERY_EX} && $urandom_range(0, 9) == 0) begin
          w.x = $urandom();
          w.y = $urandom();
          w.z = $urandom();
        end
        send_word(w, 1'b1);
      end
    end

    // Drain, let the block settle, then give the verdict.
    wait_idle();
    if (board.pending_hits.size() != 0)
      board.report($sformatf("%0d result words never arrived", board.pending_hits.size()));
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
